// ===== rtl/mstb_pkg.sv =====
// Shared types and command codes for the interval timer bank.
package mstb_pkg;

    typedef enum logic [3:0] {
        KIND_TICK       = 4'd0,
        KIND_CREATE_FOR = 4'd1,
        KIND_CREATE_CNT = 4'd2,
        KIND_DELETE     = 4'd3,
        KIND_ENABLE     = 4'd4,
        KIND_DISABLE    = 4'd5,
        KIND_TOGGLE     = 4'd6,
        KIND_RESTART    = 4'd7,
        KIND_CHANGE     = 4'd8,
        KIND_QUERY      = 4'd9,
        KIND_DEL_ALL    = 4'd10
    } kind_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_USED = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;
    localparam logic [1:0] ST_ZERO_RUN = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  timer_id;
        logic [31:0] interval;
        logic [15:0] run_count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_id;
        logic        enabled;
        logic [31:0] remaining;
        logic [15:0] fired_mask;
        logic [4:0]  active_count;
    } rsp_t;

endpackage

// ===== rtl/multi_slot_interval_timer_bank.sv =====
// Top level of the interval timer bank.
// A tick item passes the read, scan and output states: the engine reads each slot's
// timing entry from a memory with one read port, one slot per cycle, and fires due slots.
// Other commands pass the read, execute and output states. The input register accepts the
// next item while the engine works; the result waits in an output register until taken.
// Freed slots are marked free in flip-flops; their memory entry is rewritten on create.
module multi_slot_interval_timer_bank #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32,
    parameter int RUN_BITS  = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mstb_pkg::cmd_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mstb_pkg::rsp_t out_data
);
    logic           q_valid, q_take;
    mstb_pkg::cmd_t q_data;

    mstb_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
    );

    mstb_engine #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .RUN_BITS(RUN_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule

// ===== rtl/mstb_ram.sv =====
// Generic RAM with one write port and one registered read port.
module mstb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/mstb_front.sv =====
// Input stage: registers each item into a one-entry queue for the engine.
module mstb_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  mstb_pkg::cmd_t in_data,
    output logic         q_valid,
    input  logic         q_take,
    output mstb_pkg::cmd_t q_data
);
    logic           full_reg;
    mstb_pkg::cmd_t data_reg;

    assign in_ready = !full_reg;
    assign q_valid  = full_reg;
    assign q_data   = data_reg;

    // Queue slot holds one item until the engine takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            full_reg <= 1'b1;
        end
        else if (q_take)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end
endmodule

// ===== rtl/mstb_engine.sv =====
// Command engine: slot state, tick scan over the timing memory, results.
module mstb_engine #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32,
    parameter int RUN_BITS  = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_take,
    input  mstb_pkg::cmd_t q_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mstb_pkg::rsp_t out_data
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW = 2 * TIME_BITS + 2 * RUN_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EXEC = 5'b00100,
        S_SCAN = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] last;
        logic [RUN_BITS-1:0]  limit;
        logic [RUN_BITS-1:0]  runs;
    } entry_t;

    state_t               state_reg, state_next;
    logic [SLOTS-1:0]     used_reg, en_reg, fore_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [4:0]           cnt_reg;
    logic [IW:0]          idx_reg;
    mstb_pkg::cmd_t       cmd_reg;
    mstb_pkg::rsp_t       rsp_reg;
    logic                 we;
    logic [IW-1:0]        waddr, raddr;
    entry_t               wdata, rdata;
    logic [IW-1:0]        free_idx;
    logic                 free_any;
    logic                 id_ok;
    logic [IW-1:0]        id;
    logic [TIME_BITS-1:0] elapsed;
    logic [RUN_BITS-1:0]  runs_inc;
    logic [15:0]          fire_bit;

    // Lowest free slot.
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    assign id_ok   = ({1'b0, cmd_reg.timer_id} < 5'(SLOTS)) || (SLOTS >= 16);
    assign id      = IW'(cmd_reg.timer_id);
    assign elapsed = now_reg - rdata.last;
    assign runs_inc = rdata.runs + 1'b1;
    // The read is registered, so the scan address runs one slot ahead.
    assign raddr   = (state_reg == S_SCAN) ? IW'(idx_reg + 1'b1) :
                     ((state_reg == S_RD) && (cmd_reg.kind == mstb_pkg::KIND_TICK)) ?
                     '0 : id;
    assign q_take  = (state_reg == S_IDLE) && q_valid;
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = rsp_reg;

    // Slots above the mask width shift out and are not shown.
    assign fire_bit = 16'd1 << idx_reg;

    mstb_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Memory write selection.
    always_comb
    begin
        we    = 1'b0;
        waddr = id;
        wdata = rdata;
        if (state_reg == S_EXEC)
        begin
            unique case (cmd_reg.kind)
                mstb_pkg::KIND_CREATE_FOR, mstb_pkg::KIND_CREATE_CNT:
                begin
                    we = free_any && !(cmd_reg.kind == mstb_pkg::KIND_CREATE_CNT
                         && RUN_BITS'(cmd_reg.run_count) == '0);
                    waddr = free_idx;
                    wdata.period = TIME_BITS'(cmd_reg.interval);
                    wdata.last   = now_reg;
                    wdata.limit  = (cmd_reg.kind == mstb_pkg::KIND_CREATE_FOR) ?
                                   '0 : RUN_BITS'(cmd_reg.run_count);
                    wdata.runs   = '0;
                end
                mstb_pkg::KIND_ENABLE, mstb_pkg::KIND_CHANGE:
                begin
                    we = id_ok && used_reg[id];
                    wdata.last = now_reg;
                    if (cmd_reg.kind == mstb_pkg::KIND_CHANGE)
                    begin
                        wdata.period = TIME_BITS'(cmd_reg.interval);
                    end
                end
                mstb_pkg::KIND_TOGGLE:
                begin
                    we = id_ok && used_reg[id] && !en_reg[id];
                    wdata.last = now_reg;
                end
                mstb_pkg::KIND_RESTART:
                begin
                    we = id_ok && used_reg[id];
                    wdata.last = now_reg;
                    wdata.runs = '0;
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_SCAN)
        begin
            waddr = idx_reg[IW-1:0];
            wdata.last = now_reg;
            wdata.runs = runs_inc;
            we = used_reg[idx_reg[IW-1:0]] && en_reg[idx_reg[IW-1:0]]
                 && (elapsed >= rdata.period);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_RD;
            S_RD:   state_next = (cmd_reg.kind == mstb_pkg::KIND_TICK) ? S_SCAN : S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_SCAN: if (idx_reg == (IW+1)'(SLOTS - 1)) state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            en_reg    <= '0;
            fore_reg  <= '0;
            now_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                end
                S_RD:
                begin
                    if (cmd_reg.kind == mstb_pkg::KIND_TICK)
                    begin
                        now_reg <= now_reg + 1'b1;
                    end
                end
                S_EXEC:
                begin
                    unique case (cmd_reg.kind)
                        mstb_pkg::KIND_CREATE_FOR, mstb_pkg::KIND_CREATE_CNT:
                        begin
                            if (we)
                            begin
                                used_reg[free_idx] <= 1'b1;
                                en_reg[free_idx]   <= 1'b1;
                                fore_reg[free_idx] <=
                                    (cmd_reg.kind == mstb_pkg::KIND_CREATE_FOR);
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                        mstb_pkg::KIND_DELETE:
                        begin
                            if (id_ok && used_reg[id])
                            begin
                                used_reg[id] <= 1'b0;
                                en_reg[id]   <= 1'b0;
                                fore_reg[id] <= 1'b0;
                                cnt_reg <= cnt_reg - 1'b1;
                            end
                        end
                        mstb_pkg::KIND_ENABLE, mstb_pkg::KIND_RESTART:
                        begin
                            if (id_ok && used_reg[id]) en_reg[id] <= 1'b1;
                        end
                        mstb_pkg::KIND_DISABLE:
                        begin
                            if (id_ok && used_reg[id]) en_reg[id] <= 1'b0;
                        end
                        mstb_pkg::KIND_TOGGLE:
                        begin
                            if (id_ok && used_reg[id]) en_reg[id] <= !en_reg[id];
                        end
                        mstb_pkg::KIND_DEL_ALL:
                        begin
                            used_reg <= '0;
                            en_reg   <= '0;
                            fore_reg <= '0;
                            cnt_reg  <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (we && !fore_reg[idx_reg[IW-1:0]] && (runs_inc >= rdata.limit))
                    begin
                        used_reg[idx_reg[IW-1:0]] <= 1'b0;
                        en_reg[idx_reg[IW-1:0]]   <= 1'b0;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_OUT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Item capture and result build.
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            cmd_reg <= q_data;
        end
        if (state_reg == S_RD)
        begin
            rsp_reg <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            if (we) rsp_reg.fired_mask <= rsp_reg.fired_mask | fire_bit;
            rsp_reg.active_count <= cnt_reg;
            if (we && !fore_reg[idx_reg[IW-1:0]] && (runs_inc >= rdata.limit))
            begin
                rsp_reg.active_count <= cnt_reg - 1'b1;
            end
        end
        else if (state_reg == S_EXEC)
        begin
            rsp_reg.active_count <= cnt_reg;
            unique case (cmd_reg.kind)
                mstb_pkg::KIND_TICK:
                begin
                end
                mstb_pkg::KIND_CREATE_FOR, mstb_pkg::KIND_CREATE_CNT:
                begin
                    if (cmd_reg.kind == mstb_pkg::KIND_CREATE_CNT
                        && RUN_BITS'(cmd_reg.run_count) == '0)
                    begin
                        rsp_reg.status <= mstb_pkg::ST_ZERO_RUN;
                    end
                    else if (!free_any)
                    begin
                        rsp_reg.status <= mstb_pkg::ST_NO_FREE;
                    end
                    else
                    begin
                        rsp_reg.slot_id      <= 4'(free_idx);
                        rsp_reg.enabled      <= 1'b1;
                        rsp_reg.active_count <= cnt_reg + 1'b1;
                    end
                end
                mstb_pkg::KIND_DELETE, mstb_pkg::KIND_ENABLE, mstb_pkg::KIND_DISABLE,
                mstb_pkg::KIND_TOGGLE, mstb_pkg::KIND_RESTART, mstb_pkg::KIND_CHANGE,
                mstb_pkg::KIND_QUERY:
                begin
                    if (!(id_ok && used_reg[id]))
                    begin
                        rsp_reg.status <= mstb_pkg::ST_NOT_USED;
                    end
                    else
                    begin
                        unique case (cmd_reg.kind)
                            mstb_pkg::KIND_DELETE:
                            begin
                                rsp_reg.enabled <= 1'b0;
                                rsp_reg.active_count <= cnt_reg - 1'b1;
                            end
                            mstb_pkg::KIND_ENABLE, mstb_pkg::KIND_RESTART:
                                rsp_reg.enabled <= 1'b1;
                            mstb_pkg::KIND_DISABLE:
                                rsp_reg.enabled <= 1'b0;
                            mstb_pkg::KIND_TOGGLE:
                                rsp_reg.enabled <= !en_reg[id];
                            mstb_pkg::KIND_CHANGE:
                                rsp_reg.enabled <= en_reg[id];
                            default:
                            begin
                                rsp_reg.enabled <= en_reg[id];
                                if (en_reg[id] && elapsed < rdata.period)
                                begin
                                    rsp_reg.remaining <= 32'(rdata.period - elapsed);
                                end
                            end
                        endcase
                    end
                end
                mstb_pkg::KIND_DEL_ALL:
                    rsp_reg.active_count <= '0;
                default:
                begin
                end
            endcase
        end
    end
endmodule

// ===== rtl/mstb_checker.sv =====
// Port-level checker for the interval timer bank, bound to the top level.
module mstb_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input mstb_pkg::rsp_t out_data
);
    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // The bank never reports more than sixteen slots in use.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.active_count <= 5'd16)
        else $error("active count out of range");

    // A failed command never reports an enabled slot.
    a_fail_en: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != mstb_pkg::ST_OK |-> !out_data.enabled)
        else $error("failed command shows enabled");

    // Fired slots only appear with an OK status and no remaining time.
    a_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fired_mask != '0 |-> out_data.status == mstb_pkg::ST_OK
        && out_data.remaining == '0)
        else $error("fired mask on a non-tick result");

    // The input register holds one item, so an accepted item blocks the next cycle.
    a_in_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while the register was full");
endmodule

bind multi_slot_interval_timer_bank mstb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the interval timer bank.
`timescale 1ns / 1ps

module tb_top;

    localparam int NSLOT = 16;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    mstb_pkg::cmd_t in_data;
    logic out_valid;
    logic out_ready;
    mstb_pkg::rsp_t out_data;

    multi_slot_interval_timer_bank u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the timer bank.
    logic [31:0] now_ticks;
    logic        sh_used    [NSLOT];
    logic        sh_en      [NSLOT];
    logic        sh_forever [NSLOT];
    logic [31:0] sh_period  [NSLOT];
    logic [31:0] sh_last    [NSLOT];
    logic [15:0] sh_limit   [NSLOT];
    logic [15:0] sh_runs    [NSLOT];
    logic [4:0]  sh_count;

    mstb_pkg::rsp_t pending_rsp[$];
    int          errors;
    int          send_gap_pct;
    int          recv_stall_pct;

    // Directed stimulus with optional typed-in answers.
    typedef struct {
        mstb_pkg::cmd_t cmd;
        bit             fixed;
        mstb_pkg::rsp_t rsp;
    } dir_row_t;
    dir_row_t dir_rows[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void release_slot(int i);
        sh_used[i]    = 1'b0;
        sh_en[i]      = 1'b0;
        sh_forever[i] = 1'b0;
        sh_period[i]  = '0;
        sh_last[i]    = '0;
        sh_limit[i]   = '0;
        sh_runs[i]    = '0;
        if (sh_count > 5'd0)
            sh_count = sh_count - 5'd1;
    endfunction

    function automatic void clear_bank();
        now_ticks = '0;
        sh_count  = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            sh_used[i]    = 1'b0;
            sh_en[i]      = 1'b0;
            sh_forever[i] = 1'b0;
            sh_period[i]  = '0;
            sh_last[i]    = '0;
            sh_limit[i]   = '0;
            sh_runs[i]    = '0;
        end
    endfunction

    // Computes the response of one command and updates the shadow bank.
    function automatic mstb_pkg::rsp_t timer_bank_step(mstb_pkg::cmd_t c);
        mstb_pkg::rsp_t r;
        int          id;
        int          fi;
        logic [31:0] el;
        r  = '0;
        id = c.timer_id;
        fi = -1;
        if (c.kind == mstb_pkg::KIND_TICK)
        begin
            now_ticks = now_ticks + 32'd1;
            for (int i = 0; i < NSLOT; i++)
            begin
                if (sh_used[i] && sh_en[i] && (now_ticks - sh_last[i]) >= sh_period[i])
                begin
                    sh_last[i] = now_ticks;
                    sh_runs[i] = sh_runs[i] + 16'd1;
                    r.fired_mask[i] = 1'b1;
                    if (!sh_forever[i] && sh_runs[i] >= sh_limit[i])
                        release_slot(i);
                end
            end
        end
        else if (c.kind == mstb_pkg::KIND_CREATE_FOR || c.kind == mstb_pkg::KIND_CREATE_CNT)
        begin
            if (c.kind == mstb_pkg::KIND_CREATE_CNT && c.run_count == 16'd0)
                r.status = mstb_pkg::ST_ZERO_RUN;
            else
            begin
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!sh_used[i])
                        fi = i;
                if (fi < 0)
                    r.status = mstb_pkg::ST_NO_FREE;
                else
                begin
                    sh_used[fi]    = 1'b1;
                    sh_en[fi]      = 1'b1;
                    sh_forever[fi] = (c.kind == mstb_pkg::KIND_CREATE_FOR);
                    sh_period[fi]  = c.interval;
                    sh_last[fi]    = now_ticks;
                    sh_limit[fi]   = (c.kind == mstb_pkg::KIND_CREATE_FOR) ?
                                     16'd0 : c.run_count;
                    sh_runs[fi]    = '0;
                    sh_count       = sh_count + 5'd1;
                    r.slot_id      = fi[3:0];
                    r.enabled      = 1'b1;
                end
            end
        end
        else if (c.kind >= mstb_pkg::KIND_DELETE && c.kind <= mstb_pkg::KIND_QUERY)
        begin
            if (!sh_used[id])
                r.status = mstb_pkg::ST_NOT_USED;
            else
            begin
                case (c.kind)
                    mstb_pkg::KIND_DELETE: release_slot(id);
                    mstb_pkg::KIND_ENABLE:
                    begin
                        sh_en[id]   = 1'b1;
                        sh_last[id] = now_ticks;
                    end
                    mstb_pkg::KIND_DISABLE: sh_en[id] = 1'b0;
                    mstb_pkg::KIND_TOGGLE:
                    begin
                        sh_en[id] = ~sh_en[id];
                        if (sh_en[id])
                            sh_last[id] = now_ticks;
                    end
                    mstb_pkg::KIND_RESTART:
                    begin
                        sh_last[id] = now_ticks;
                        sh_runs[id] = '0;
                        sh_en[id]   = 1'b1;
                    end
                    mstb_pkg::KIND_CHANGE:
                    begin
                        sh_period[id] = c.interval;
                        sh_last[id]   = now_ticks;
                    end
                    default:
                    begin
                        el = now_ticks - sh_last[id];
                        if (sh_en[id] && el < sh_period[id])
                            r.remaining = sh_period[id] - el;
                    end
                endcase
                r.enabled = sh_en[id];
            end
        end
        else if (c.kind == mstb_pkg::KIND_DEL_ALL)
        begin
            for (int i = 0; i < NSLOT; i++)
                if (sh_used[i])
                    release_slot(i);
        end
        r.active_count = sh_count;
        return r;
    endfunction

    function automatic mstb_pkg::cmd_t make_cmd(logic [3:0] k, logic [3:0] id,
                                                logic [31:0] iv, logic [15:0] rc);
        mstb_pkg::cmd_t c;
        c.kind      = k;
        c.timer_id  = id;
        c.interval  = iv;
        c.run_count = rc;
        return c;
    endfunction

    function automatic void add_row(mstb_pkg::cmd_t c, bit fx, mstb_pkg::rsp_t r);
        dir_row_t d;
        d.cmd   = c;
        d.fixed = fx;
        d.rsp   = r;
        dir_rows.push_back(d);
    endfunction

    // Random command, mostly meaningful, with short intervals so slots fire.
    function automatic mstb_pkg::cmd_t rand_cmd();
        mstb_pkg::cmd_t c;
        int   p;
        p = $urandom_range(0, 99);
        c.timer_id  = 4'($urandom_range(0, 15));
        c.run_count = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        case ($urandom_range(0, 9))
            0:       c.interval = $urandom;
            1:       c.interval = 32'hFFFF_FFFF;
            default: c.interval = $urandom_range(0, 6);
        endcase
        if (p < 35)
            c.kind = mstb_pkg::KIND_TICK;
        else if (p < 50)
            c.kind = mstb_pkg::KIND_CREATE_FOR;
        else if (p < 65)
            c.kind = mstb_pkg::KIND_CREATE_CNT;
        else if (p < 97)
            c.kind = 4'($urandom_range(3, 9));
        else if (p < 98)
            c.kind = mstb_pkg::KIND_DEL_ALL;
        else
            c.kind = 4'($urandom_range(11, 15));
        return c;
    endfunction

    // Sender: holds each item until it is accepted; valid drops only in idle gaps.
    task automatic send_item(mstb_pkg::cmd_t c);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Receiver: random back-pressure and response check.
    always @(posedge clk)
    begin
        mstb_pkg::rsp_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response %h", $realtime, out_data);
                    errors++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (out_data.status !== want.status
                        || out_data.slot_id !== want.slot_id
                        || out_data.enabled !== want.enabled
                        || out_data.remaining !== want.remaining
                        || out_data.fired_mask !== want.fired_mask
                        || out_data.active_count !== want.active_count)
                    begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $realtime, want, out_data);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        mstb_pkg::cmd_t c;
        mstb_pkg::rsp_t r;
        mstb_pkg::rsp_t z;
        int   wait_cycles;
        errors         = 0;
        send_gap_pct   = 12;
        recv_stall_pct = 64;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        clear_bank();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: typed-in answers where obvious.
        z = '0;
        r = z; r.status = mstb_pkg::ST_NOT_USED;
        add_row(make_cmd(mstb_pkg::KIND_QUERY, 4'd15, '0, '0), 1, r);
        r = z; r.status = mstb_pkg::ST_ZERO_RUN;
        add_row(make_cmd(mstb_pkg::KIND_CREATE_CNT, 4'd0, 32'hFFFF_FFFF, 16'd0), 1, r);
        r = z; r.enabled = 1'b1; r.active_count = 5'd1;
        add_row(make_cmd(mstb_pkg::KIND_CREATE_FOR, 4'd15, 32'd0, 16'hFFFF), 1, r);
        r = z; r.fired_mask = 16'h0001; r.active_count = 5'd1;
        add_row(make_cmd(mstb_pkg::KIND_TICK, '0, '0, '0), 1, r);
        add_row(make_cmd(mstb_pkg::KIND_CREATE_CNT, 4'd0, 32'd1, 16'd2), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_CREATE_FOR, 4'd0, 32'hFFFF_FFFF, 16'd0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_CREATE_CNT, 4'd0, 32'd3, 16'hFFFF), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_QUERY, 4'd2, '0, '0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_TICK, '0, '0, '0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_TICK, '0, '0, '0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_DISABLE, 4'd2, '0, '0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_QUERY, 4'd2, '0, '0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_TOGGLE, 4'd2, '0, '0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_ENABLE, 4'd3, '0, '0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_RESTART, 4'd3, '0, '0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_CHANGE, 4'd3, 32'd2, '0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_QUERY, 4'd3, '0, '0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_DELETE, 4'd0, '0, '0), 0, z);
        add_row(make_cmd(4'd15, 4'd0, '0, '0), 0, z);
        for (int i = 0; i < 16; i++)
            add_row(make_cmd(mstb_pkg::KIND_CREATE_FOR, 4'd0, 32'd5, 16'd1), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_CREATE_CNT, 4'd0, 32'd5, 16'd0), 0, z);
        add_row(make_cmd(mstb_pkg::KIND_DEL_ALL, 4'd0, '0, '0), 0, z);

        foreach (dir_rows[n])
        begin
            r = timer_bank_step(dir_rows[n].cmd);
            pending_rsp.push_back(dir_rows[n].fixed ? dir_rows[n].rsp : r);
            send_item(dir_rows[n].cmd);
        end

        // Random part in three idling phases.
        for (int n = 0; n < 1450; n++)
        begin
            if (n == 480)
            begin
                send_gap_pct   = 64;
                recv_stall_pct = 12;
            end
            if (n == 960)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            c = rand_cmd();
            pending_rsp.push_back(timer_bank_step(c));
            send_item(c);
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_rsp.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mstb_pkg.sv
rtl/mstb_ram.sv
rtl/mstb_front.sv
rtl/mstb_engine.sv
rtl/multi_slot_interval_timer_bank.sv
rtl/mstb_checker.sv
verif/tb_top.sv
